// ===== rtl/cea_pkg.sv =====
// ----------------------------------------------------------------------------
// cea_pkg: shared definitions for the execute stage alu and branch unit
// opcode codes, status codes and the per-stage pipeline record
// ----------------------------------------------------------------------------
package cea_pkg;

    // register group
    localparam logic [5:0] OP_ADD   = 6'h01;
    localparam logic [5:0] OP_SUB   = 6'h02;
    localparam logic [5:0] OP_AND   = 6'h03;
    localparam logic [5:0] OP_OR    = 6'h04;
    localparam logic [5:0] OP_XOR   = 6'h05;
    localparam logic [5:0] OP_SLL   = 6'h06;
    localparam logic [5:0] OP_SRL   = 6'h07;
    localparam logic [5:0] OP_SRA   = 6'h08;
    localparam logic [5:0] OP_MUL   = 6'h09;
    localparam logic [5:0] OP_DIV   = 6'h0A;
    localparam logic [5:0] OP_REM   = 6'h0B;
    localparam logic [5:0] OP_RNOP  = 6'h0C;
    localparam logic [5:0] OP_MOV   = 6'h0D;
    localparam logic [5:0] OP_NOT   = 6'h0E;
    localparam logic [5:0] OP_NEG   = 6'h0F;
    // immediate group
    localparam logic [5:0] OP_ADDI  = 6'h10;
    localparam logic [5:0] OP_SUBI  = 6'h11;
    localparam logic [5:0] OP_ANDI  = 6'h12;
    localparam logic [5:0] OP_ORI   = 6'h13;
    localparam logic [5:0] OP_XORI  = 6'h14;
    localparam logic [5:0] OP_SLLI  = 6'h15;
    localparam logic [5:0] OP_SRLI  = 6'h16;
    localparam logic [5:0] OP_SRAI  = 6'h17;
    localparam logic [5:0] OP_INOP  = 6'h18;
    localparam logic [5:0] OP_LI    = 6'h19;
    localparam logic [5:0] OP_LD_LO = 6'h1A;
    localparam logic [5:0] OP_ST_HI = 6'h21;
    // branch group
    localparam logic [5:0] OP_BEQ   = 6'h22;
    localparam logic [5:0] OP_BNE   = 6'h23;
    localparam logic [5:0] OP_BLE   = 6'h24;
    localparam logic [5:0] OP_BGE   = 6'h25;
    localparam logic [5:0] OP_BLEU  = 6'h26;
    localparam logic [5:0] OP_BGEU  = 6'h27;
    // jump group
    localparam logic [5:0] OP_JMP   = 6'h28;
    localparam logic [5:0] OP_JAL   = 6'h29;
    localparam logic [5:0] OP_JALR  = 6'h2A;
    localparam logic [5:0] OP_HALT  = 6'h32;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    // one pipeline stage record
    typedef struct packed {
        logic [5:0]  op;
        logic [31:0] res;
        logic [31:0] npc;
        logic        chg;
        logic        hlt;
        logic [1:0]  st;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] dq;
        logic [32:0] rem;
        logic [31:0] dvs;
        logic        qneg;
        logic        rneg;
    } t_stage;

endpackage

// ===== rtl/cpu_execute_alu_branch_top.sv =====
// ----------------------------------------------------------------------------
// cpu_execute_alu_branch_top: pipelined execute stage
// alu, multiply, divide, branch resolution; one instruction per unstalled cycle
// ----------------------------------------------------------------------------
// usage
//   slave stream carries one instruction per request: opcode, rs1, rs2,
//   immediate and pc packed in s_axis_tdata. master stream returns one
//   result per request: result value, next pc, pc changed, halt, status.
//   from accept to result valid an instruction passes one decode and alu
//   stage, one multiply stage, 32 divide stages (one quotient bit each)
//   and one sign fix stage that is also the output register.
//   throughput is one instruction per cycle while the output is not
//   stalled; every instruction walks the full pipe so results leave in order.
//   all stages advance together; when the receiver holds tready low with
//   a result waiting, the whole pipe freezes and s_axis_tready drops,
//   nothing is lost or repeated. empty slots are not squeezed out while
//   the output is stalled. synchronous active low reset clears all valid
//   bits.
// ----------------------------------------------------------------------------
module cpu_execute_alu_branch_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // opcode[5:0], rs1_value[37:6], rs2_value[69:38], immediate[101:70],
    // current_pc[133:102], zero fill[135:134]
    input  logic [135:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // result_value[31:0], next_pc[63:32], pc_changed[64], halt[65],
    // status[67:66], zero fill[71:68]
    output logic [71:0]  o_m_axis_tdata
);

    localparam int NST  = 35;
    localparam int LAST = NST - 1;

    cea_pkg::t_stage r_s [NST];
    cea_pkg::t_stage n_s [NST];
    logic [NST-1:0]  r_v;
    logic            ena;

    logic [5:0]  in_op;
    logic [31:0] in_a, in_b, in_imm, in_pc;

    assign in_op  = i_s_axis_tdata[5:0];
    assign in_a   = i_s_axis_tdata[37:6];
    assign in_b   = i_s_axis_tdata[69:38];
    assign in_imm = i_s_axis_tdata[101:70];
    assign in_pc  = i_s_axis_tdata[133:102];

    // pipe moves when the output slot is empty or being taken
    assign ena             = !r_v[LAST] || i_m_axis_tready;
    assign o_s_axis_tready = ena;

    // decode and alu stage
    always_comb begin
        logic        take;
        logic [31:0] sum_ai;
        n_s[0]      = '0;
        take        = 1'b0;
        sum_ai      = in_a + in_imm;
        n_s[0].op   = in_op;
        n_s[0].npc  = in_pc;
        n_s[0].ma   = in_a;
        n_s[0].mb   = in_b;
        n_s[0].qneg = in_a[31] ^ in_b[31];
        n_s[0].rneg = in_a[31];
        case (in_op)
            cea_pkg::OP_ADD:  n_s[0].res = in_a + in_b;
            cea_pkg::OP_SUB:  n_s[0].res = in_a - in_b;
            cea_pkg::OP_AND:  n_s[0].res = in_a & in_b;
            cea_pkg::OP_OR:   n_s[0].res = in_a | in_b;
            cea_pkg::OP_XOR:  n_s[0].res = in_a ^ in_b;
            cea_pkg::OP_SLL:  n_s[0].res = in_a << in_b[4:0];
            cea_pkg::OP_SRL:  n_s[0].res = in_a >> in_b[4:0];
            cea_pkg::OP_SRA:  n_s[0].res = 32'($signed(in_a) >>> in_b[4:0]);
            cea_pkg::OP_MUL, cea_pkg::OP_RNOP, cea_pkg::OP_INOP: ;
            cea_pkg::OP_DIV, cea_pkg::OP_REM: begin
                if (in_b == '0) n_s[0].st = cea_pkg::ST_DIVZERO;
            end
            cea_pkg::OP_MOV:  n_s[0].res = in_a;
            cea_pkg::OP_NOT:  n_s[0].res = ~in_a;
            cea_pkg::OP_NEG:  n_s[0].res = 32'd0 - in_a;
            cea_pkg::OP_ADDI: n_s[0].res = sum_ai;
            cea_pkg::OP_SUBI: n_s[0].res = in_a - in_imm;
            cea_pkg::OP_ANDI: n_s[0].res = in_a & in_imm;
            cea_pkg::OP_ORI:  n_s[0].res = in_a | in_imm;
            cea_pkg::OP_XORI: n_s[0].res = in_a ^ in_imm;
            cea_pkg::OP_SLLI: n_s[0].res = in_a << in_imm[4:0];
            cea_pkg::OP_SRLI: n_s[0].res = in_a >> in_imm[4:0];
            cea_pkg::OP_SRAI: n_s[0].res = 32'($signed(in_a) >>> in_imm[4:0]);
            cea_pkg::OP_LI:   n_s[0].res = in_imm;
            cea_pkg::OP_BEQ:  take = (in_a == in_b);
            cea_pkg::OP_BNE:  take = (in_a != in_b);
            cea_pkg::OP_BLE:  take = ($signed(in_a) <= $signed(in_b));
            cea_pkg::OP_BGE:  take = ($signed(in_a) >= $signed(in_b));
            cea_pkg::OP_BLEU: take = (in_a <= in_b);
            cea_pkg::OP_BGEU: take = (in_a >= in_b);
            cea_pkg::OP_JMP:  take = 1'b1;
            cea_pkg::OP_JAL: begin
                n_s[0].res = in_pc;
                take       = 1'b1;
            end
            cea_pkg::OP_JALR: begin
                n_s[0].res = in_pc;
                n_s[0].npc = {sum_ai[31:1], 1'b0};
                n_s[0].chg = 1'b1;
            end
            cea_pkg::OP_HALT: n_s[0].hlt = 1'b1;
            default: begin
                if (in_op >= cea_pkg::OP_LD_LO && in_op <= cea_pkg::OP_ST_HI) begin
                    n_s[0].res = sum_ai;
                end else begin
                    n_s[0].st = cea_pkg::ST_ILLEGAL;
                end
            end
        endcase
        if (take) begin
            n_s[0].npc = in_pc + in_imm;
            n_s[0].chg = 1'b1;
        end
    end

    // multiply stage, divider operand magnitudes
    always_comb begin
        logic [31:0] prod;
        n_s[1]     = r_s[0];
        prod       = 32'(r_s[0].ma * r_s[0].mb);
        if (r_s[0].op == cea_pkg::OP_MUL) n_s[1].res = prod;
        n_s[1].dq  = r_s[0].ma[31] ? 32'd0 - r_s[0].ma : r_s[0].ma;
        n_s[1].dvs = r_s[0].mb[31] ? 32'd0 - r_s[0].mb : r_s[0].mb;
        n_s[1].rem = '0;
    end

    // restoring divide, one quotient bit per stage
    for (genvar g = 2; g < LAST; g++) begin : g_div
        always_comb begin
            logic [32:0] rsh;
            logic        qb;
            n_s[g]     = r_s[g-1];
            rsh        = {r_s[g-1].rem[31:0], r_s[g-1].dq[31]};
            qb         = (rsh >= {1'b0, r_s[g-1].dvs});
            n_s[g].rem = qb ? rsh - {1'b0, r_s[g-1].dvs} : rsh;
            n_s[g].dq  = {r_s[g-1].dq[30:0], qb};
        end
    end

    // sign fix and result select
    always_comb begin
        n_s[LAST] = r_s[LAST-1];
        if (r_s[LAST-1].st == cea_pkg::ST_OK) begin
            if (r_s[LAST-1].op == cea_pkg::OP_DIV) begin
                n_s[LAST].res = r_s[LAST-1].qneg ? 32'd0 - r_s[LAST-1].dq
                                                 : r_s[LAST-1].dq;
            end else if (r_s[LAST-1].op == cea_pkg::OP_REM) begin
                n_s[LAST].res = r_s[LAST-1].rneg ? 32'd0 - r_s[LAST-1].rem[31:0]
                                                 : r_s[LAST-1].rem[31:0];
            end
        end
    end

    // stage registers and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (ena) begin
            r_v <= {r_v[NST-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (ena) begin
            for (int i = 0; i < NST; i++) r_s[i] <= n_s[i];
        end
    end

    assign o_m_axis_tvalid = r_v[LAST];
    assign o_m_axis_tdata  = {4'd0, r_s[LAST].st, r_s[LAST].hlt, r_s[LAST].chg,
                              r_s[LAST].npc, r_s[LAST].res};

`ifndef SYNTHESIS
    // status code 3 is never produced
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_s[LAST].st != 2'd3))
        else $error("status out of range");

    // any error leaves result zero and pc unchanged
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_s[LAST].st != cea_pkg::ST_OK)
            |-> (r_s[LAST].res == '0 && !r_s[LAST].chg && !r_s[LAST].hlt))
        else $error("error result not clean");

    // halt never changes the pc
    a_halt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_s[LAST].hlt)
            |-> (!r_s[LAST].chg && r_s[LAST].st == cea_pkg::ST_OK))
        else $error("halt with pc change or error");

    // divide by zero only on divide opcodes
    a_dz_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_s[LAST].st == cea_pkg::ST_DIVZERO)
            |-> (r_s[LAST].op == cea_pkg::OP_DIV || r_s[LAST].op == cea_pkg::OP_REM))
        else $error("divide error on other opcode");
`endif

endmodule
